@@ rtl/core/mtem_pkg.sv @@
// Shared constants for the timer expiry manager: codes, limits and defaults.
`default_nettype none
package mtem_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int ID_BITS_DEF    = 32;

  // Most timers fired by one tick.
  localparam int MAX_FIRE = 16;

  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 3;
  localparam int DELAY_W = 16;
  localparam int RID_W   = 32;

  localparam logic [FUNC_W-1:0] FUNC_REG    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXTEND = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_REG    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXTEND = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DONE  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/multi_timer_expiry_manager_core.sv @@
// Top level of the timer expiry manager: slot memory, scan sequencer and result port.
//
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+---------------------------
//  input   | in_func, in_timer_id, in_delay_ms                 | beat at start & !busy
//  result  | out_kind, out_result_id, out_ok, out_last         | beat when out_valid is high
//
// A register beat is handled in the idle state without a scan; its reply shows on the next cycle.
// Cancel and extend scan the slot memory once before the reply.
// A tick scans once per fired timer plus one closing scan;
// at the fire limit the flush state takes the place of the closing scan.
// The single read port of the slot memory sets the scan length.
// Reset clears the live bits, the clock and the id counter at once; no clearing pass.
// busy stays high until the last result of a beat is out; results cannot be held off.
`default_nettype none
module multi_timer_expiry_manager_core #(
  parameter int NUM_TIMERS = mtem_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = mtem_pkg::TIME_BITS_DEF,
  parameter int ID_BITS    = mtem_pkg::ID_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mtem_pkg::FUNC_W-1:0]       in_func,
  input  wire logic [mtem_pkg::RID_W-1:0]        in_timer_id,
  input  wire logic signed [mtem_pkg::DELAY_W-1:0] in_delay_ms,
  output logic                                   out_valid,
  output logic [mtem_pkg::KIND_W-1:0]            out_kind,
  output logic [mtem_pkg::RID_W-1:0]             out_result_id,
  output logic                                   out_ok,
  output logic                                   out_last
);

  localparam int AW  = $clog2(NUM_TIMERS);
  localparam int CW  = $clog2(NUM_TIMERS + 1);
  localparam int FCW = $clog2(mtem_pkg::MAX_FIRE + 1);
  localparam int DW  = ID_BITS + TIME_BITS;

  localparam logic [TIME_BITS-1:0] TIME_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

  mtem_pkg::state_t state_r, state_nxt;

  logic [NUM_TIMERS-1:0]     live_r, live_nxt;
  logic [TIME_BITS-1:0]      now_r, now_nxt;
  logic [ID_BITS-1:0]        idc_r, idc_nxt;
  logic [CW-1:0]             scan_r, scan_nxt;
  logic                      rd_pend_r;
  logic [AW-1:0]             rd_idx_r;
  logic [DW-1:0]             rd_data_r;
  logic                      best_found_r, best_found_nxt;
  logic [AW-1:0]             best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0]      best_key_r, best_key_nxt;
  logic [ID_BITS-1:0]        best_hdl_r, best_hdl_nxt;
  logic [TIME_BITS-1:0]      best_exp_r, best_exp_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic [ID_BITS-1:0]        pend_hdl_r, pend_hdl_nxt;
  logic [FCW-1:0]            fire_cnt_r, fire_cnt_nxt;
  logic [mtem_pkg::FUNC_W-1:0] op_r, op_nxt;
  logic [mtem_pkg::RID_W-1:0]  tid_r, tid_nxt;
  logic [TIME_BITS-1:0]      dly_r, dly_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mtem_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [mtem_pkg::RID_W-1:0]  out_id_r, out_id_nxt;
  logic                        out_ok_r, out_ok_nxt;
  logic                        out_last_r, out_last_nxt;

  // Slot memory: handle in the upper bits, expiry in the lower bits.
  logic [DW-1:0] slot_mem [NUM_TIMERS];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic          free_found;
  logic [AW-1:0] free_idx;

  logic [ID_BITS-1:0]   rd_hdl;
  logic [TIME_BITS-1:0] rd_exp;
  logic [TIME_BITS-1:0] rd_diff;
  logic [TIME_BITS-1:0] rd_key;
  logic                 rd_live;
  logic                 rd_expired;
  logic                 accept;

  assign accept  = start && (state_r == mtem_pkg::ST_IDLE);
  assign busy    = (state_r != mtem_pkg::ST_IDLE);
  assign rd_en   = (state_r == mtem_pkg::ST_SCAN) && (scan_r < CW'(NUM_TIMERS));
  assign rd_addr = scan_r[AW-1:0];

  assign rd_hdl     = rd_data_r[DW-1:TIME_BITS];
  assign rd_exp     = rd_data_r[TIME_BITS-1:0];
  assign rd_diff    = rd_exp - now_r;
  assign rd_key     = rd_diff ^ TIME_SIGN;
  assign rd_live    = live_r[rd_idx_r];
  assign rd_expired = (rd_diff == '0) || rd_diff[TIME_BITS-1];

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    now_nxt        = now_r;
    idc_nxt        = idc_r;
    scan_nxt       = scan_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_hdl_nxt   = best_hdl_r;
    best_exp_nxt   = best_exp_r;
    pend_v_nxt     = pend_v_r;
    pend_hdl_nxt   = pend_hdl_r;
    fire_cnt_nxt   = fire_cnt_r;
    op_nxt         = op_r;
    tid_nxt        = tid_r;
    dly_nxt        = dly_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_ok_nxt     = out_ok_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      mtem_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_func;
          tid_nxt        = in_timer_id;
          dly_nxt        = TIME_BITS'(in_delay_ms);
          scan_nxt       = '0;
          best_found_nxt = 1'b0;
          case (in_func)
            mtem_pkg::FUNC_REG: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = mtem_pkg::KIND_REG;
              out_last_nxt  = 1'b1;
              if (free_found) begin
                idc_nxt            = idc_r + 1'b1;
                live_nxt[free_idx] = 1'b1;
                wr_en              = 1'b1;
                wr_addr            = free_idx;
                wr_data            = {idc_nxt, now_r + TIME_BITS'(in_delay_ms)};
                out_id_nxt         = mtem_pkg::RID_W'(idc_nxt);
                out_ok_nxt         = 1'b1;
              end else begin
                out_id_nxt = '0;
                out_ok_nxt = 1'b0;
              end
            end
            mtem_pkg::FUNC_TICK: begin
              now_nxt      = now_r + 1'b1;
              pend_v_nxt   = 1'b0;
              fire_cnt_nxt = '0;
              state_nxt    = mtem_pkg::ST_SCAN;
            end
            default: begin
              state_nxt = mtem_pkg::ST_SCAN;
            end
          endcase
        end
      end

      mtem_pkg::ST_SCAN: begin
        if (scan_r < CW'(NUM_TIMERS)) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          state_nxt = mtem_pkg::ST_DONE;
        end
        if (rd_pend_r && rd_live) begin
          if (op_r == mtem_pkg::FUNC_TICK) begin
            if (rd_expired && (!best_found_r || (rd_key < best_key_r) ||
                ((rd_key == best_key_r) && (rd_hdl < best_hdl_r)))) begin
              best_found_nxt = 1'b1;
              best_idx_nxt   = rd_idx_r;
              best_key_nxt   = rd_key;
              best_hdl_nxt   = rd_hdl;
            end
          end else if (!best_found_r && (rd_hdl == ID_BITS'(tid_r))) begin
            // first match wins on duplicate handles
            best_found_nxt = 1'b1;
            best_idx_nxt   = rd_idx_r;
            best_hdl_nxt   = rd_hdl;
            best_exp_nxt   = rd_exp;
          end
        end
      end

      mtem_pkg::ST_DONE: begin
        if (op_r == mtem_pkg::FUNC_TICK) begin
          if (best_found_r) begin
            live_nxt[best_idx_r] = 1'b0;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = mtem_pkg::KIND_FIRE;
              out_id_nxt    = mtem_pkg::RID_W'(pend_hdl_r);
              out_ok_nxt    = 1'b1;
              out_last_nxt  = 1'b0;
            end
            // hold this firing until the next pass tells whether it is the last
            pend_v_nxt     = 1'b1;
            pend_hdl_nxt   = best_hdl_r;
            fire_cnt_nxt   = fire_cnt_r + 1'b1;
            scan_nxt       = '0;
            best_found_nxt = 1'b0;
            if (fire_cnt_r == FCW'(mtem_pkg::MAX_FIRE - 1)) begin
              state_nxt = mtem_pkg::ST_FLUSH;
            end else begin
              state_nxt = mtem_pkg::ST_SCAN;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b1;
            out_last_nxt  = 1'b1;
            if (pend_v_r) begin
              out_kind_nxt = mtem_pkg::KIND_FIRE;
              out_id_nxt   = mtem_pkg::RID_W'(pend_hdl_r);
            end else begin
              out_kind_nxt = mtem_pkg::KIND_IDLE;
              out_id_nxt   = '0;
            end
            pend_v_nxt = 1'b0;
            state_nxt  = mtem_pkg::ST_IDLE;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = (op_r == mtem_pkg::FUNC_CANCEL) ? mtem_pkg::KIND_CANCEL
                                                          : mtem_pkg::KIND_EXTEND;
          out_id_nxt    = tid_r;
          out_ok_nxt    = best_found_r;
          out_last_nxt  = 1'b1;
          if (best_found_r) begin
            if (op_r == mtem_pkg::FUNC_CANCEL) begin
              live_nxt[best_idx_r] = 1'b0;
            end else begin
              wr_en   = 1'b1;
              wr_addr = best_idx_r;
              wr_data = {best_hdl_r, best_exp_r + dly_r};
            end
          end
          state_nxt = mtem_pkg::ST_IDLE;
        end
      end

      mtem_pkg::ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = mtem_pkg::KIND_FIRE;
        out_id_nxt    = mtem_pkg::RID_W'(pend_hdl_r);
        out_ok_nxt    = 1'b1;
        out_last_nxt  = 1'b1;
        pend_v_nxt    = 1'b0;
        state_nxt     = mtem_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = mtem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mtem_pkg::ST_IDLE;
      live_r       <= '0;
      now_r        <= '0;
      idc_r        <= '0;
      scan_r       <= '0;
      rd_pend_r    <= 1'b0;
      best_found_r <= 1'b0;
      pend_v_r     <= 1'b0;
      fire_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      now_r        <= now_nxt;
      idc_r        <= idc_nxt;
      scan_r       <= scan_nxt;
      rd_pend_r    <= rd_en;
      best_found_r <= best_found_nxt;
      pend_v_r     <= pend_v_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tid_r      <= tid_nxt;
    dly_r      <= dly_nxt;
    rd_idx_r   <= rd_addr;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_hdl_r <= best_hdl_nxt;
    best_exp_r <= best_exp_nxt;
    pend_hdl_r <= pend_hdl_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_ok        = out_ok_r;
  assign out_last      = out_last_r;

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtem_pkg::ST_IDLE) |-> !rd_pend_r)
    else $error("read in flight while idle");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= FCW'(mtem_pkg::MAX_FIRE))
    else $error("fire count beyond limit");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != mtem_pkg::KIND_FIRE)) |-> out_last_r)
    else $error("reply without last");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == mtem_pkg::KIND_FIRE)) |-> out_ok_r)
    else $error("fired result without ok");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == mtem_pkg::FUNC_TICK)) |=> busy)
    else $error("tick did not start a scan");

endmodule
`default_nettype wire

@@ verif/mtem_reply_checker.sv @@
// Checker for the timer expiry manager: predicts each accepted beat's replies and compares.
`timescale 1ns / 100ps
module mtem_reply_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [mtem_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [mtem_pkg::RID_W-1:0]      in_timer_id,
  input  wire logic [mtem_pkg::DELAY_W-1:0]    in_delay_ms,
  input  wire logic                            out_valid,
  input  wire logic [mtem_pkg::KIND_W-1:0]     out_kind,
  input  wire logic [mtem_pkg::RID_W-1:0]      out_result_id,
  input  wire logic                            out_ok,
  input  wire logic                            out_last,
  output int unsigned                          fail_count,
  output int unsigned                          reply_pending,
  output int unsigned                          reply_count,
  output int unsigned                          fired_count,
  output int unsigned                          full_count,
  output int unsigned                          idle_count
);
  import mtem_pkg::*;

  localparam int NT = NUM_TIMERS_DEF;
  localparam int TW = TIME_BITS_DEF;
  localparam int IW = ID_BITS_DEF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RID_W-1:0]  rid;
    logic              ok;
    logic              last;
  } timer_reply_t;

  logic          slot_live   [NT];
  logic [IW-1:0] slot_handle [NT];
  logic [TW-1:0] slot_expiry [NT];
  logic [TW-1:0] now_ms;
  logic [IW-1:0] id_counter;
  timer_reply_t  reply_q [$];

  function automatic timer_reply_t mk_reply(logic [KIND_W-1:0] kind, logic [RID_W-1:0] rid,
                                            logic ok, logic last);
    timer_reply_t r;
    r.kind = kind;
    r.rid  = rid;
    r.ok   = ok;
    r.last = last;
    return r;
  endfunction

  task automatic predict_beat(input logic [FUNC_W-1:0] func, input logic [RID_W-1:0] tid,
                              input logic [DELAY_W-1:0] delay);
    logic [TW-1:0] delay_ext;
    logic [TW-1:0] d;
    logic [TW-1:0] key;
    logic [TW-1:0] best_key;
    int            slot;
    int            best;
    int            fired;
    bit            scanning;
    timer_reply_t  held;
    delay_ext = TW'($signed(delay));
    case (func)
      FUNC_REG: begin
        slot = -1;
        for (int i = NT - 1; i >= 0; i--) begin
          if (!slot_live[i]) slot = i;
        end
        if (slot < 0) begin
          reply_q.push_back(mk_reply(KIND_REG, '0, 1'b0, 1'b1));
          full_count++;
        end else begin
          id_counter        = id_counter + 1'b1;
          slot_live[slot]   = 1'b1;
          slot_handle[slot] = id_counter;
          slot_expiry[slot] = now_ms + delay_ext;
          reply_q.push_back(mk_reply(KIND_REG, RID_W'(id_counter), 1'b1, 1'b1));
        end
      end
      FUNC_CANCEL, FUNC_EXTEND: begin
        // lowest-numbered matching slot wins
        slot = -1;
        for (int i = NT - 1; i >= 0; i--) begin
          if (slot_live[i] && slot_handle[i] == IW'(tid)) slot = i;
        end
        if (slot >= 0) begin
          if (func == FUNC_CANCEL) slot_live[slot] = 1'b0;
          else slot_expiry[slot] = slot_expiry[slot] + delay_ext;
        end
        reply_q.push_back(mk_reply(func == FUNC_CANCEL ? KIND_CANCEL : KIND_EXTEND, tid,
                                   slot >= 0, 1'b1));
      end
      default: begin
        now_ms   = now_ms + 1'b1;
        fired    = 0;
        scanning = 1'b1;
        held     = '0;
        while (scanning && fired < MAX_FIRE) begin
          best     = -1;
          best_key = '0;
          for (int i = 0; i < NT; i++) begin
            d = slot_expiry[i] - now_ms;
            if (slot_live[i] && (d == '0 || d[TW-1])) begin
              // bias the signed difference so an unsigned compare orders it
              key = d ^ {1'b1, {(TW-1){1'b0}}};
              if (best < 0 || key < best_key ||
                  (key == best_key && slot_handle[i] < slot_handle[best])) begin
                best     = i;
                best_key = key;
              end
            end
          end
          if (best < 0) begin
            scanning = 1'b0;
          end else begin
            if (fired > 0) reply_q.push_back(held);
            held = mk_reply(KIND_FIRE, RID_W'(slot_handle[best]), 1'b1, 1'b0);
            slot_live[best] = 1'b0;
            fired++;
          end
        end
        if (fired == 0) begin
          reply_q.push_back(mk_reply(KIND_IDLE, '0, 1'b1, 1'b1));
          idle_count++;
        end else begin
          held.last = 1'b1;
          reply_q.push_back(held);
          fired_count += fired;
        end
      end
    endcase
  endtask

  task automatic check_reply();
    timer_reply_t want;
    reply_count++;
    if (reply_q.size() == 0) begin
      $error("unexpected result: kind %0d, result_id %0h, ok %0b, last %0b",
             out_kind, out_result_id, out_ok, out_last);
      fail_count++;
    end else begin
      want = reply_q.pop_front();
      if (out_kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
        fail_count++;
      end
      if (out_result_id !== want.rid) begin
        $error("out_result_id: expected %0h, got %0h", want.rid, out_result_id);
        fail_count++;
      end
      if (out_ok !== want.ok) begin
        $error("out_ok: expected %0b, got %0b", want.ok, out_ok);
        fail_count++;
      end
      if (out_last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, out_last);
        fail_count++;
      end
    end
  endtask

  // results first: a beat accepted on the same edge only queues behind them
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        slot_live[i]   = 1'b0;
        slot_handle[i] = '0;
        slot_expiry[i] = '0;
      end
      now_ms      = '0;
      id_counter  = '0;
      fail_count  = 0;
      reply_count = 0;
      fired_count = 0;
      full_count  = 0;
      idle_count  = 0;
      reply_q.delete();
    end else begin
      if (out_valid === 1'b1) check_reply();
      if (start === 1'b1 && busy === 1'b0) predict_beat(in_func, in_timer_id, in_delay_ms);
    end
    reply_pending = reply_q.size();
  end

endmodule

@@ verif/tb_multi_timer_expiry_manager_core.sv @@
// Testbench top for the timer expiry manager: clock, reset, beat stimulus and verdict.
`timescale 1ns / 100ps
module tb_multi_timer_expiry_manager_core;
  import mtem_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [RID_W-1:0]    in_timer_id = '0;
  logic [DELAY_W-1:0]  in_delay_ms = '0;
  wire logic           busy;
  wire logic           out_valid;
  wire logic [KIND_W-1:0] out_kind;
  wire logic [RID_W-1:0]  out_result_id;
  wire logic           out_ok;
  wire logic           out_last;

  int unsigned fail_count;
  int unsigned reply_pending;
  int unsigned reply_count;
  int unsigned fired_count;
  int unsigned full_count;
  int unsigned idle_count;

  int unsigned beat_count = 0;
  int unsigned reg_sent = 0;
  int unsigned func_count [4] = '{0, 0, 0, 0};

  multi_timer_expiry_manager_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_timer_id   (in_timer_id),
    .in_delay_ms   (in_delay_ms),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_result_id (out_result_id),
    .out_ok        (out_ok),
    .out_last      (out_last)
  );

  mtem_reply_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_timer_id   (in_timer_id),
    .in_delay_ms   (in_delay_ms),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_result_id (out_result_id),
    .out_ok        (out_ok),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .reply_pending (reply_pending),
    .reply_count   (reply_count),
    .fired_count   (fired_count),
    .full_count    (full_count),
    .idle_count    (idle_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout: results still outstanding");
    $display("Test completed with failures");
    $finish;
  end

  // Hold the beat until accepted, then maybe drop start and idle for a while.
  task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [RID_W-1:0] tid,
                           input logic [DELAY_W-1:0] delay, input int unsigned idle_pct);
    start       = 1'b1;
    in_func     = func;
    in_timer_id = tid;
    in_delay_ms = delay;
    @(posedge clk);
    while (busy) @(posedge clk);
    beat_count++;
    func_count[func]++;
    if (func == FUNC_REG) reg_sent++;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 24)) begin
        in_func     = FUNC_W'($urandom);
        in_timer_id = $urandom;
        in_delay_ms = DELAY_W'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (reply_pending != 0) @(negedge clk);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return DELAY_W'(int'($urandom_range(20)) - 4);
    if (r < 75) return DELAY_W'($urandom);
    if (r < 85) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    return DELAY_W'($urandom_range(60));
  endfunction

  // Aim mostly at recently issued handles so cancel and extend find live timers.
  function automatic logic [RID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return RID_W'(reg_sent - $urandom_range(0, reg_sent < 20 ? reg_sent : 20));
    if (r < 80) return $urandom;
    if (r < 90) return (r % 2) ? '0 : '1;
    return RID_W'(reg_sent + 1 + $urandom_range(3));
  endfunction

  initial begin
    int unsigned idle_pct [4] = '{0, 53, 17, 0};
    int unsigned phase_end;
    int unsigned r;
    int unsigned n;
    int unsigned d;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle tick, misses, delay extremes with wrap, extend into the past
    send_beat(FUNC_TICK, $urandom, DELAY_W'($urandom), 0);
    send_beat(FUNC_CANCEL, 32'h0000_0000, 16'h0000, 0);
    send_beat(FUNC_EXTEND, 32'hffff_ffff, 16'h0001, 0);
    send_beat(FUNC_REG, $urandom, 16'h7fff, 0);
    send_beat(FUNC_REG, $urandom, 16'h8000, 0);
    send_beat(FUNC_REG, $urandom, 16'h0000, 0);
    send_beat(FUNC_EXTEND, 32'd1, 16'h8000, 0);
    send_beat(FUNC_CANCEL, 32'd3, DELAY_W'($urandom), 0);
    send_beat(FUNC_TICK, $urandom, DELAY_W'($urandom), 0);
    // fill the table with tied expiries, overflow it, then fire all at once
    for (int k = 0; k < NUM_TIMERS_DEF; k++) begin
      send_beat(FUNC_REG, $urandom, DELAY_W'(1 - (k % 4)), 0);
    end
    send_beat(FUNC_REG, $urandom, 16'h0005, 0);
    send_beat(FUNC_TICK, $urandom, DELAY_W'($urandom), 0);
    start = 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      phase_end = beat_count + 61;
      while (beat_count < phase_end) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // batch with one expiry, then tick until it goes off
          n = $urandom_range(2, 8);
          d = $urandom_range(3);
          repeat (n) send_beat(FUNC_REG, $urandom, DELAY_W'(d), idle_pct[p]);
          repeat (d + 1) send_beat(FUNC_TICK, $urandom, DELAY_W'($urandom), idle_pct[p]);
        end else if (r < 42) begin
          send_beat(FUNC_TICK, $urandom, DELAY_W'($urandom), idle_pct[p]);
        end else if (r < 66) begin
          send_beat(FUNC_REG, $urandom, pick_delay(), idle_pct[p]);
        end else if (r < 83) begin
          send_beat(FUNC_CANCEL, pick_id(), DELAY_W'($urandom), idle_pct[p]);
        end else begin
          send_beat(FUNC_EXTEND, pick_id(), pick_delay(), idle_pct[p]);
        end
      end
      start = 1'b0;
      wait_drained();
    end

    repeat (4 * NUM_TIMERS_DEF) @(negedge clk);
    $display("Run covered %0d beats: %0d register, %0d cancel, %0d extend, %0d tick.",
             beat_count, func_count[FUNC_REG], func_count[FUNC_CANCEL],
             func_count[FUNC_EXTEND], func_count[FUNC_TICK]);
    $display("Checked %0d results: %0d firings, %0d table-full replies, %0d idle ticks.",
             reply_count, fired_count, full_count, idle_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ multi_timer_expiry_manager_core.f @@
rtl/core/mtem_pkg.sv
rtl/core/multi_timer_expiry_manager_core.sv
verif/mtem_reply_checker.sv
verif/tb_multi_timer_expiry_manager_core.sv
